### sv/efrc8_pkg.sv
`timescale 1ns / 1ps
// shared types, register indexes and the crc-8 step for the frame receiver
// no dependencies

package efrc8_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_START_FLAG = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_FLAG   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ESC_FLAG   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_LIMIT = 3'd4;

  localparam logic [7:0]  START_FLAG_RST = 8'd2;
  localparam logic [7:0]  END_FLAG_RST   = 8'd3;
  localparam logic [7:0]  ESC_FLAG_RST   = 8'd27;
  localparam logic [31:0] TIMEOUT_RST    = 32'd1000;
  localparam logic [7:0]  BYTE_LIMIT_RST = 8'd70;

  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam logic [7:0] CRC_INIT = 8'h00;

  localparam int OUT_IDX_W = 6;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_READ,
    ST_LOAD
  } state_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### sv/escaped_frame_receiver_crc8_core.sv
`timescale 1ns / 1ps
// byte-stuffed frame receiver with running crc-8 check and payload readout
// depends on efrc8_pkg and efrc8_ram

// While a frame is being parsed the block takes one received byte per cycle:
// the flag decode, the timeout and length checks and the crc-8 update all
// happen in the accept cycle, and plain or escaped payload bytes are
// written to the payload buffer. On an end flag that closes a good frame the
// block stops taking bytes and drains the buffer: one buffer read and one
// output register load per result, waiting while the output side stalls;
// an empty payload skips the buffer read and gives a single result. The input
// stays held until the last result is loaded. Bad frames are dropped without
// any result and do not hold the input. The buffer needs no clearing after
// reset. Configuration is always ready; write it only while the block is idle.

module escaped_frame_receiver_crc8_core #(
  parameter int PAYLOAD_CAPACITY = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          in_rx_byte,
  input  logic [31:0]                         in_now,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [7:0]                          out_packet_id,
  output logic [7:0]                          out_data_byte,
  output logic [efrc8_pkg::OUT_IDX_W-1:0]     out_byte_index,
  output logic [efrc8_pkg::OUT_IDX_W-1:0]     out_payload_length,
  output logic                                out_last,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [efrc8_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [efrc8_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int CNT_W  = $clog2(PAYLOAD_CAPACITY + 1);
  localparam int ADDR_W = $clog2(PAYLOAD_CAPACITY);
  localparam logic [CNT_W-1:0] CAP = CNT_W'(PAYLOAD_CAPACITY);

  // configuration
  logic [7:0]  sof_byte_r, eof_byte_r, esc_byte_r, byte_limit_r;
  logic [31:0] timeout_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sof_byte_r   <= efrc8_pkg::START_FLAG_RST;
      eof_byte_r   <= efrc8_pkg::END_FLAG_RST;
      esc_byte_r   <= efrc8_pkg::ESC_FLAG_RST;
      timeout_r    <= efrc8_pkg::TIMEOUT_RST;
      byte_limit_r <= efrc8_pkg::BYTE_LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        efrc8_pkg::CFG_START_FLAG: sof_byte_r   <= cfg_data[7:0];
        efrc8_pkg::CFG_END_FLAG:   eof_byte_r   <= cfg_data[7:0];
        efrc8_pkg::CFG_ESC_FLAG:   esc_byte_r   <= cfg_data[7:0];
        efrc8_pkg::CFG_TIMEOUT:    timeout_r    <= cfg_data;
        efrc8_pkg::CFG_BYTE_LIMIT: byte_limit_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // frame state
  efrc8_pkg::state_t state_r, state_nxt;
  logic [7:0]        pos_r;
  logic [31:0]       start_stamp_r;
  logic [7:0]        decl_len_r;
  logic [7:0]        ident_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              esc_r;
  logic [7:0]        crc_all_r;
  logic [7:0]        crc_prev_r;
  logic [7:0]        last_byte_r;
  logic [CNT_W-1:0]  plen_r;
  logic [ADDR_W-1:0] rd_idx_r;

  // output register
  logic                          out_valid_r;
  logic [7:0]                    out_id_r;
  logic [7:0]                    out_data_r;
  logic [efrc8_pkg::OUT_IDX_W-1:0] out_idx_r;
  logic [efrc8_pkg::OUT_IDX_W-1:0] out_len_r;
  logic                          out_last_r;

  logic       accept;
  logic       load_out;
  logic       rd_last;
  logic [7:0] rd_data;

  // byte decode
  logic        in_frame;
  logic        abandon;
  logic        is_esc;
  logic        is_end;
  logic        is_store;
  logic        full;
  logic        frame_ok;
  logic [31:0] elapsed;
  logic        wr_en;

  assign accept   = in_valid && in_ready;
  assign in_frame = (pos_r != 8'd0) && (pos_r != 8'd1) && (pos_r != 8'd2);
  assign elapsed  = in_now - start_stamp_r;
  assign abandon  = (pos_r > byte_limit_r) || (elapsed > timeout_r);
  assign is_esc   = !esc_r && (in_rx_byte == esc_byte_r);
  assign is_end   = !esc_r && !is_esc && (in_rx_byte == eof_byte_r);
  assign is_store = !is_esc && !is_end;
  assign full     = (cnt_r == CAP);
  assign frame_ok = (cnt_r != '0)
                    && (({1'b0, pos_r} + 9'd1) == {1'b0, decl_len_r})
                    && (crc_prev_r == last_byte_r);
  assign wr_en    = accept && in_frame && !abandon && is_store && !full;
  assign rd_last  = (CNT_W'(rd_idx_r) == (plen_r - CNT_W'(1))) || (plen_r == '0);

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      efrc8_pkg::ST_RUN: begin
        in_ready = 1'b1;
        if (accept && in_frame && !abandon && is_end && frame_ok) begin
          state_nxt = (cnt_r == CNT_W'(1)) ? efrc8_pkg::ST_LOAD : efrc8_pkg::ST_READ;
        end
      end
      efrc8_pkg::ST_READ: begin
        state_nxt = efrc8_pkg::ST_LOAD;
      end
      efrc8_pkg::ST_LOAD: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = rd_last ? efrc8_pkg::ST_RUN : efrc8_pkg::ST_READ;
        end
      end
      default: state_nxt = efrc8_pkg::ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= efrc8_pkg::ST_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r         <= 8'd0;
      start_stamp_r <= 32'd0;
      decl_len_r    <= 8'd0;
      ident_r       <= 8'd0;
      cnt_r         <= '0;
      esc_r         <= 1'b0;
      crc_all_r     <= efrc8_pkg::CRC_INIT;
      crc_prev_r    <= efrc8_pkg::CRC_INIT;
    end else if (accept) begin
      if (pos_r == 8'd0) begin
        if (in_rx_byte == sof_byte_r) begin
          start_stamp_r <= in_now;
          pos_r         <= 8'd1;
          cnt_r         <= '0;
          esc_r         <= 1'b0;
          crc_all_r     <= efrc8_pkg::CRC_INIT;
          crc_prev_r    <= efrc8_pkg::CRC_INIT;
        end
      end else if (pos_r == 8'd1) begin
        decl_len_r <= in_rx_byte;
        pos_r      <= 8'd2;
      end else if (pos_r == 8'd2) begin
        ident_r <= in_rx_byte;
        pos_r   <= 8'd3;
      end else if (abandon || is_end || (is_store && full)) begin
        pos_r <= 8'd0;
        esc_r <= 1'b0;
      end else if (is_esc) begin
        esc_r <= 1'b1;
        pos_r <= pos_r + 8'd1;
      end else begin
        esc_r      <= 1'b0;
        pos_r      <= pos_r + 8'd1;
        cnt_r      <= cnt_r + CNT_W'(1);
        crc_prev_r <= crc_all_r;
        crc_all_r  <= efrc8_pkg::crc8_byte(crc_all_r, in_rx_byte);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      last_byte_r <= in_rx_byte;
    end
  end

  // readout control
  always_ff @(posedge clk) begin
    if (accept && in_frame && !abandon && is_end) begin
      plen_r   <= cnt_r - CNT_W'(1);
      rd_idx_r <= '0;
    end else if (load_out && !rd_last) begin
      rd_idx_r <= rd_idx_r + ADDR_W'(1);
    end
  end

  efrc8_ram #(
    .DEPTH (PAYLOAD_CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cnt_r[ADDR_W-1:0]),
    .wr_data (in_rx_byte),
    .rd_addr (rd_idx_r),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_id_r   <= ident_r;
      out_data_r <= (plen_r == '0) ? 8'd0 : rd_data;
      out_idx_r  <= efrc8_pkg::OUT_IDX_W'(rd_idx_r);
      out_len_r  <= efrc8_pkg::OUT_IDX_W'(plen_r);
      out_last_r <= rd_last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_packet_id      = out_id_r;
  assign out_data_byte      = out_data_r;
  assign out_byte_index     = out_idx_r;
  assign out_payload_length = out_len_r;
  assign out_last           = out_last_r;

endmodule

### sv/efrc8_ram.sv
`timescale 1ns / 1ps
// payload buffer: one write port, one read port with registered read data
// no dependencies

module efrc8_ram #(
  parameter int DEPTH = 64,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
